>>> design/igmp_router_membership_engine_top_macros.svh
// assertion helpers for the membership engine
`ifndef IGMP_ROUTER_MEMBERSHIP_ENGINE_TOP_MACROS_SVH
`define IGMP_ROUTER_MEMBERSHIP_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define IGMPRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IGMPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/igmpre_pkg.sv
`timescale 1ns / 1ps
package igmpre_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam logic [15:0] QUERY_RESPONSE_TENTHS = 16'd100;

	// operation codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_QUERY  = 3'd2;
	localparam logic [2:0] OP_REPORT = 3'd3;
	localparam logic [2:0] OP_LEAVE  = 3'd4;

	// action codes
	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_GENQ   = 3'd1;
	localparam logic [2:0] ACT_GRPQ   = 3'd2;
	localparam logic [2:0] ACT_ADD    = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;
	localparam logic [2:0] ACT_FULL   = 3'd5;

	// router modes
	localparam logic [1:0] MODE_INITIAL    = 2'd0;
	localparam logic [1:0] MODE_QUERIER    = 2'd1;
	localparam logic [1:0] MODE_NONQUERIER = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_ENABLE     = 3'd0;
	localparam logic [2:0] CFG_OWN_ADDR   = 3'd1;
	localparam logic [2:0] CFG_QUERY_INT  = 3'd2;
	localparam logic [2:0] CFG_MEMBER_INT = 3'd3;
	localparam logic [2:0] CFG_OTHER_INT  = 3'd4;
	localparam logic [2:0] CFG_STARTUP    = 3'd5;
	localparam logic [2:0] CFG_LM_INT     = 3'd6;
	localparam logic [2:0] CFG_LM_COUNT   = 3'd7;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] group_address;
		logic [31:0] sender_address;
		logic [7:0]  max_response;
	} in_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] target_group;
		logic [15:0] response_time;
		logic        last;
	} out_t;

	// token handed from cell to cell
	typedef struct packed {
		logic v;
		logic done;
	} tok_t;

	// result raised by a cell or the controller
	typedef struct packed {
		logic        v;
		logic [2:0]  act;
		logic [31:0] grp;
		logic [15:0] resp;
	} emit_t;

	// command broadcast to all cells
	typedef struct packed {
		logic        adv;
		logic        claim;
		logic [2:0]  op;
		logic [31:0] grp;
		logic [1:0]  mode;
		logic [15:0] lmi;
		logic [19:0] mstart;
		logic [19:0] qstart;
		logic [19:0] lstart;
		logic [15:0] rstart;
	} cell_cmd_t;

	function automatic logic [15:0] max1_16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic logic [19:0] max1_20(input logic [19:0] v);
		return (v == 20'd0) ? 20'd1 : v;
	endfunction

endpackage

>>> design/igmp_router_membership_engine_top.sv
// IGMPv2 router membership engine for one interface. One input beat is taken at a time;
// in_stall stays high until every result beat of the current input has been handed to the
// output register. Group entries live in a row of TABLE_ENTRIES cells that a token walks one
// cell per cycle whenever the output register is not held by out_stall. A tick walks the row
// once, a report for a new group twice (a match pass and then a free-entry pass), a leave,
// group query or report for a known group once, and start, general query and ignored inputs
// not at all. Results come out in table order, the final beat of each input carries last.
`timescale 1ns / 1ps
`include "igmp_router_membership_engine_top_macros.svh"
module igmp_router_membership_engine_top
	import igmpre_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  state_q;
	in_t         cmd_q;
	logic [1:0]  mode_q;
	logic [15:0] qcnt_q;
	logic        pass_q;
	logic        inj_q;
	logic        pend_v_q;
	emit_t       pend_q;
	logic        out_v_q;
	out_t        out_q;

	logic        en_q;
	logic [31:0] own_q;
	logic [15:0] qi_q, mi_q, oqi_q, sqi_q, lmi_q;
	logic [3:0]  lmc_q;

	logic        adv;
	logic        nonq;
	emit_t       em;
	cell_cmd_t   ccmd;
	tok_t        tail;
	tok_t        chain_in [TABLE_ENTRIES];
	tok_t        chain_out [TABLE_ENTRIES];
	emit_t       cell_em [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] tok_vec;
	logic [11:0] qprod;
	logic [19:0] lprod;

	assign adv = !out_v_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_v_q;
	assign out_data = out_q;
	assign nonq = cmd_q.sender_address < own_q;

	// timer start values shared by all cells
	assign qprod = {4'd0, cmd_q.max_response} * {8'd0, lmc_q};
	assign lprod = {4'd0, lmi_q} * {16'd0, lmc_q};

	always_comb begin
		ccmd.adv = adv;
		ccmd.claim = pass_q;
		ccmd.op = cmd_q.operation;
		ccmd.grp = cmd_q.group_address;
		ccmd.mode = mode_q;
		ccmd.lmi = lmi_q;
		ccmd.mstart = max1_20({4'd0, mi_q});
		ccmd.qstart = max1_20({8'd0, qprod});
		ccmd.lstart = max1_20(lprod);
		ccmd.rstart = max1_16(lmi_q);
	end

	// row of entry cells
	genvar k;
	generate
		for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign chain_in[k] = '{v: inj_q && (state_q == ST_WALK), done: 1'b0};
			end else begin : g_link
				assign chain_in[k] = chain_out[k-1];
			end
			igmpre_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (ccmd),
				.tok_in  (chain_in[k]),
				.tok_out (chain_out[k]),
				.em      (cell_em[k])
			);
			assign tok_vec[k] = chain_out[k].v;
		end
	endgenerate

	assign tail = chain_out[TABLE_ENTRIES-1];

	// result of this cycle: active cell or controller
	always_comb begin
		em = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			em = em | cell_em[i];
		end
		if (state_q == ST_HEAD && en_q) begin
			if (cmd_q.operation == OP_START) begin
				em = '{v: 1'b1, act: ACT_GENQ, grp: 32'd0, resp: QUERY_RESPONSE_TENTHS};
			end else if (cmd_q.operation == OP_TICK && qcnt_q == 16'd1 &&
					mode_q != MODE_INITIAL) begin
				em = '{v: 1'b1, act: ACT_GENQ, grp: 32'd0, resp: QUERY_RESPONSE_TENTHS};
			end
		end
		if (state_q == ST_WALK && tail.v && pass_q && !tail.done) begin
			em = '{v: 1'b1, act: ACT_FULL, grp: cmd_q.group_address, resp: 16'd0};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			own_q <= 32'd0;
			qi_q <= 16'd1250;
			mi_q <= 16'd2600;
			oqi_q <= 16'd2550;
			sqi_q <= 16'd312;
			lmi_q <= 16'd10;
			lmc_q <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:     en_q <= cfg_data[0];
				CFG_OWN_ADDR:   own_q <= cfg_data;
				CFG_QUERY_INT:  qi_q <= cfg_data[15:0];
				CFG_MEMBER_INT: mi_q <= cfg_data[15:0];
				CFG_OTHER_INT:  oqi_q <= cfg_data[15:0];
				CFG_STARTUP:    sqi_q <= cfg_data[15:0];
				CFG_LM_INT:     lmi_q <= cfg_data[15:0];
				CFG_LM_COUNT:   lmc_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= in_data;
		end
	end

	// sequencer, router state and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_INITIAL;
			qcnt_q <= 16'd0;
			pass_q <= 1'b0;
			inj_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				if (in_valid) begin
					state_q <= ST_HEAD;
				end
			end
			if (adv) begin
				case (state_q)
					ST_HEAD: begin
						pass_q <= 1'b0;
						if (!en_q) begin
							state_q <= ST_FIN;
						end else begin
							case (cmd_q.operation)
								OP_TICK: begin
									if (qcnt_q != 16'd0) begin
										if (qcnt_q == 16'd1 && mode_q != MODE_INITIAL) begin
											mode_q <= MODE_QUERIER;
											qcnt_q <= max1_16(qi_q);
										end else begin
											qcnt_q <= qcnt_q - 16'd1;
										end
									end
									state_q <= ST_WALK;
									inj_q <= 1'b1;
								end
								OP_START: begin
									mode_q <= MODE_QUERIER;
									qcnt_q <= max1_16(sqi_q);
									state_q <= ST_FIN;
								end
								OP_QUERY: begin
									if (nonq) begin
										qcnt_q <= max1_16(oqi_q);
										mode_q <= MODE_NONQUERIER;
									end
									if (cmd_q.group_address != 32'd0 &&
											(nonq || mode_q == MODE_NONQUERIER)) begin
										state_q <= ST_WALK;
										inj_q <= 1'b1;
									end else begin
										state_q <= ST_FIN;
									end
								end
								OP_REPORT, OP_LEAVE: begin
									if (cmd_q.group_address == 32'd0) begin
										state_q <= ST_FIN;
									end else begin
										state_q <= ST_WALK;
										inj_q <= 1'b1;
									end
								end
								default: state_q <= ST_FIN;
							endcase
						end
					end
					ST_WALK: begin
						inj_q <= 1'b0;
						if (tail.v) begin
							if (cmd_q.operation == OP_REPORT && !pass_q && !tail.done) begin
								pass_q <= 1'b1;
								inj_q <= 1'b1;
							end else begin
								state_q <= ST_FIN;
							end
						end
					end
					ST_FIN: begin
						state_q <= ST_IDLE;
					end
					default: begin
					end
				endcase

				// one result held back so the final one can carry last
				if (state_q == ST_FIN) begin
					out_v_q <= 1'b1;
					pend_v_q <= 1'b0;
					if (pend_v_q) begin
						out_q <= '{action: pend_q.act, target_group: pend_q.grp,
							response_time: pend_q.resp, last: 1'b1};
					end else begin
						out_q <= '{action: ACT_NONE, target_group: 32'd0,
							response_time: 16'd0, last: 1'b1};
					end
				end else if (em.v) begin
					pend_q <= em;
					pend_v_q <= 1'b1;
					out_v_q <= pend_v_q;
					out_q <= '{action: pend_q.act, target_group: pend_q.grp,
						response_time: pend_q.resp, last: 1'b0};
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	`IGMPRE_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one token in the row")
	`IGMPRE_ASSERT_NOW(a_token_in_walk, |tok_vec, state_q == ST_WALK, "token outside walk")
	`IGMPRE_ASSERT_NOW(a_idle_empty, !in_stall, !pend_v_q, "held result while idle")
	`IGMPRE_ASSERT_NEXT(a_fin_last, (state_q == ST_FIN) && adv, out_valid && out_data.last,
		"final beat missing last")

endmodule

>>> design/igmpre_cell.sv
`timescale 1ns / 1ps
module igmpre_cell
	import igmpre_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  tok_t      tok_in,
	output tok_t      tok_out,
	output emit_t     em
);

	tok_t        tok_q;
	logic        valid_q;
	logic [31:0] group_q;
	logic        chk_q;
	logic [19:0] gc_q;
	logic [15:0] rx_q;

	logic        nv, nchk, done, hit;
	logic [31:0] ng;
	logic [19:0] ngc;
	logic [15:0] nrx;

	// entry update while this cell holds the token
	always_comb begin
		nv = valid_q;
		ng = group_q;
		nchk = chk_q;
		ngc = gc_q;
		nrx = rx_q;
		done = tok_q.done;
		em = '0;
		hit = valid_q && (group_q == cmd.grp);
		if (tok_q.v) begin
			if (cmd.claim) begin
				if (!valid_q && !tok_q.done) begin
					nv = 1'b1;
					ng = cmd.grp;
					nchk = 1'b0;
					nrx = 16'd0;
					ngc = cmd.mstart;
					done = 1'b1;
					em = '{v: 1'b1, act: ACT_ADD, grp: cmd.grp, resp: 16'd0};
				end
			end else begin
				case (cmd.op)
					OP_TICK: begin
						if (valid_q) begin
							if (gc_q <= 20'd1) begin
								nv = 1'b0;
								em = '{v: 1'b1, act: ACT_REMOVE, grp: group_q, resp: 16'd0};
							end else begin
								ngc = gc_q - 20'd1;
								if (chk_q && rx_q != 16'd0) begin
									if (rx_q == 16'd1) begin
										nrx = cmd.rstart;
										if (cmd.mode == MODE_QUERIER) begin
											em = '{v: 1'b1, act: ACT_GRPQ, grp: group_q,
												resp: cmd.lmi};
										end
									end else begin
										nrx = rx_q - 16'd1;
									end
								end
							end
						end
					end
					OP_QUERY: begin
						if (hit && !chk_q) begin
							ngc = cmd.qstart;
							nrx = 16'd0;
							nchk = 1'b1;
						end
					end
					OP_REPORT: begin
						if (hit) begin
							nchk = 1'b0;
							nrx = 16'd0;
							ngc = cmd.mstart;
							done = 1'b1;
						end
					end
					OP_LEAVE: begin
						if (hit && !chk_q && cmd.mode == MODE_QUERIER) begin
							ngc = cmd.lstart;
							nrx = cmd.rstart;
							nchk = 1'b1;
							em = '{v: 1'b1, act: ACT_GRPQ, grp: cmd.grp, resp: cmd.lmi};
						end
					end
					default: begin
					end
				endcase
			end
		end
		tok_out = '{v: tok_q.v, done: done};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			valid_q <= 1'b0;
		end else if (cmd.adv) begin
			tok_q <= tok_in;
			valid_q <= nv;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			group_q <= ng;
			chk_q <= nchk;
			gc_q <= ngc;
			rx_q <= nrx;
		end
	end

endmodule
